@@ rtl/ksm_pkg.sv @@
package ksm_pkg;

  localparam int SRC_W = 3;
  localparam int VAL_W = 32;
  localparam int CNT_W = 4;

  localparam int MAX_SOURCES_DEF = 8;
  localparam logic [CNT_W-1:0] ACTIVE_RESET = 4'd8;

  typedef struct packed {
    logic [SRC_W-1:0]        source;
    logic signed [VAL_W-1:0] value;
    logic                    end_of_source;
  } item_t;

  typedef struct packed {
    logic signed [VAL_W-1:0] merged_value;
    logic [SRC_W-1:0]        from_source;
    logic                    done_res;
  } res_t;

endpackage

@@ rtl/ksm_in_if.sv @@
interface ksm_in_if;
  logic          valid;
  logic          ready;
  ksm_pkg::item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ksm_out_if.sv @@
interface ksm_out_if;
  logic         valid;
  logic         ready;
  ksm_pkg::res_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

@@ rtl/ksm_min_tree.sv @@
module ksm_min_tree #(
  parameter int N = ksm_pkg::MAX_SOURCES_DEF
) (
  input  logic [N-1:0]                           present,
  input  logic signed [N-1:0][ksm_pkg::VAL_W-1:0] vals,
  output logic                                   found,
  output logic [$clog2(N)-1:0]                   best_idx,
  output logic signed [ksm_pkg::VAL_W-1:0]       best_val
);

  localparam int IW = $clog2(N);
  localparam int P  = 1 << IW;

  // Heap layout: node k has children 2k+1 and 2k+2, leaves start at P-1.
  logic                             nd_p [2*P-1];
  logic [IW-1:0]                    nd_i [2*P-1];
  logic signed [ksm_pkg::VAL_W-1:0] nd_v [2*P-1];

  genvar j, k;
  generate
    for (j = 0; j < P; j++) begin : g_leaf
      if (j < N) begin : g_real
        assign nd_p[P-1+j] = present[j];
        assign nd_v[P-1+j] = vals[j];
      end else begin : g_pad
        assign nd_p[P-1+j] = 1'b0;
        assign nd_v[P-1+j] = '0;
      end
      assign nd_i[P-1+j] = IW'(j);
    end

    // The left subtree always holds the lower indices, so it wins ties.
    for (k = 0; k < P-1; k++) begin : g_node
      logic take_right;
      assign take_right = nd_p[2*k+2] &&
                          (!nd_p[2*k+1] || (nd_v[2*k+2] < nd_v[2*k+1]));
      assign nd_p[k] = nd_p[2*k+1] || nd_p[2*k+2];
      assign nd_i[k] = take_right ? nd_i[2*k+2] : nd_i[2*k+1];
      assign nd_v[k] = take_right ? nd_v[2*k+2] : nd_v[2*k+1];
    end
  endgenerate

  assign found    = nd_p[0];
  assign best_idx = nd_i[0];
  assign best_val = nd_v[0];

endmodule

@@ rtl/ksm_core.sv @@
module ksm_core #(
  parameter int MAX_SOURCES = ksm_pkg::MAX_SOURCES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      step,
  input  ksm_pkg::item_t            item,
  input  logic [ksm_pkg::CNT_W-1:0] active,
  output logic                      res_valid,
  output ksm_pkg::res_t             res
);

  localparam int IW = $clog2(MAX_SOURCES);
  localparam int NW = ksm_pkg::CNT_W + $clog2(MAX_SOURCES + 1);

  logic signed [ksm_pkg::VAL_W-1:0] head_r [MAX_SOURCES];
  logic [MAX_SOURCES-1:0] valid_r, valid_nxt;
  logic [MAX_SOURCES-1:0] ended_r, ended_nxt;

  logic [NW-1:0]          n_eff;
  logic [MAX_SOURCES-1:0] act_mask;
  logic [MAX_SOURCES-1:0] hit;
  logic [MAX_SOURCES-1:0] valid_upd, ended_upd;
  logic signed [MAX_SOURCES-1:0][ksm_pkg::VAL_W-1:0] head_eff;
  logic                   all_ready;
  logic                   found;
  logic [IW-1:0]          best_idx;
  logic signed [ksm_pkg::VAL_W-1:0] best_val;

  // A count of zero acts as one; anything past the storage acts as the storage size.
  always_comb begin
    if (active == '0) begin
      n_eff = NW'(1);
    end else if (NW'(active) > NW'(MAX_SOURCES)) begin
      n_eff = NW'(MAX_SOURCES);
    end else begin
      n_eff = NW'(active);
    end
  end

  genvar i;
  generate
    for (i = 0; i < MAX_SOURCES; i++) begin : g_src
      assign act_mask[i] = NW'(i) < n_eff;
      assign hit[i] = (NW'(i) == NW'(item.source)) && (NW'(item.source) < n_eff) &&
                      !valid_r[i] && !ended_r[i];
      assign valid_upd[i] = valid_r[i] || (hit[i] && !item.end_of_source);
      assign ended_upd[i] = ended_r[i] || (hit[i] && item.end_of_source);
      assign head_eff[i]  = (hit[i] && !item.end_of_source) ? item.value : head_r[i];

      always_ff @(posedge clk) begin
        if (step && hit[i] && !item.end_of_source) begin
          head_r[i] <= item.value;
        end
      end
    end
  endgenerate

  ksm_min_tree #(
    .N (MAX_SOURCES)
  ) u_min_tree (
    .present  (valid_upd & act_mask),
    .vals     (head_eff),
    .found    (found),
    .best_idx (best_idx),
    .best_val (best_val)
  );

  assign all_ready = ((valid_upd | ended_upd) & act_mask) == act_mask;

  always_comb begin
    valid_nxt = valid_upd;
    ended_nxt = ended_upd;
    res_valid = 1'b0;
    res       = '0;
    if (all_ready) begin
      res_valid = 1'b1;
      if (found) begin
        valid_nxt[best_idx] = 1'b0;
        res.merged_value    = best_val;
        res.from_source     = ksm_pkg::SRC_W'(best_idx);
      end else begin
        // Every active source has ended: report completion and start over.
        valid_nxt    = '0;
        ended_nxt    = '0;
        res.done_res = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      ended_r <= '0;
    end else if (step) begin
      valid_r <= valid_nxt;
      ended_r <= ended_nxt;
    end
  end

endmodule

@@ rtl/k_way_sorted_merge.sv @@
// K-way merge of ascending sorted sources into one ascending stream.
// Input channel in_if: each beat carries a source number and either the next
// value of that source or an end mark. Result channel out_if: each beat is the
// smallest held head with its source number, or a done beat once every active
// source has ended. After a value beat, the named source must send its next
// beat before anything more can come out. Equal values leave lowest source first.
// The active source count is written through cfg_we/cfg_wdata; the user must
// write it only while idle, as the block itself does not enforce this. A beat
// accepted on in_if waits in the input register; the head update and the
// comparator tree then feed the output register, which presents the result
// on out_if. Throughput is one beat per cycle while the receiver does not
// stall; the comparator tree over all heads sets the critical path.
// Reset empties the input and output registers, clears all head valid and end
// flags, and sets the active count to eight. When the receiver stalls, the
// output register holds its beat, the input register fills, and in_if.ready
// drops.
module k_way_sorted_merge #(
  parameter int MAX_SOURCES = ksm_pkg::MAX_SOURCES_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  ksm_in_if.sink                    in_if,
  ksm_out_if.source                 out_if,
  input  logic                      cfg_we,
  input  logic [ksm_pkg::CNT_W-1:0] cfg_wdata
);

  logic [ksm_pkg::CNT_W-1:0] active_r;
  logic                      in_v_r;
  ksm_pkg::item_t            item_r;
  logic                      out_v_r;
  ksm_pkg::res_t             out_r;

  logic          proceed;
  logic          res_valid;
  ksm_pkg::res_t res;

  assign proceed      = in_v_r && (!out_v_r || out_if.ready);
  assign in_if.ready  = !in_v_r || proceed;
  assign out_if.valid = out_v_r;
  assign out_if.data  = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= ksm_pkg::ACTIVE_RESET;
    end else if (cfg_we) begin
      active_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else if (in_if.ready) begin
      in_v_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.ready && in_if.valid) begin
      item_r <= in_if.data;
    end
  end

  ksm_core #(
    .MAX_SOURCES (MAX_SOURCES)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (proceed),
    .item      (item_r),
    .active    (active_r),
    .res_valid (res_valid),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (proceed) begin
      out_v_r <= res_valid;
    end else if (out_if.ready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (proceed && res_valid) begin
      out_r <= res;
    end
  end

endmodule
